FILE: rtl/core/bda_pkg.sv
// Package for the button debounce and activity block.
// Shared types, field widths, thresholds and register indexes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bda_pkg;

  // Fixed widths of the request and result fields
  localparam int unsigned RAW_BITS  = 3;
  localparam int unsigned TIME_BITS = 32;

  // Configuration register widths
  localparam int unsigned SLEEP_BITS = 8;
  localparam int unsigned MASK_BITS  = 3;
  localparam int unsigned LONG_BITS  = 16;
  localparam int unsigned CFG_DATA_BITS  = 16;
  localparam int unsigned CFG_INDEX_BITS = 2;

  // Debounce thresholds on the count of set history bits
  localparam int unsigned PRESS_THRESHOLD   = 4;
  localparam int unsigned RELEASE_THRESHOLD = 4;

  // Sleep timeout unit: ten seconds in milliseconds
  localparam int unsigned MS_PER_UNIT = 10000;
  localparam int unsigned LIMIT_BITS  = SLEEP_BITS + $clog2(MS_PER_UNIT);

  localparam logic [LONG_BITS-1:0] LONG_PRESS_RESET = LONG_BITS'(1000);

  // Defaults for the top-level parameters
  localparam int unsigned NUM_BUTTONS_DEF  = 3;
  localparam int unsigned HISTORY_BITS_DEF = 8;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SLEEP_TIMEOUT = 2'd0,
    REG_HANDLER_MASK  = 2'd1,
    REG_LONG_PRESS_MS = 2'd2,
    REG_UNUSED        = 2'd3
  } cfg_reg_t;

  // What one lane reports for the current request
  typedef struct packed {
    logic held;
    logic press_event;
    logic recent;
    logic over_long;
  } lane_flags_t;

  typedef struct packed {
    logic [RAW_BITS-1:0] held_mask;
    logic [RAW_BITS-1:0] press_event;
    logic                active;
    logic                shutdown;
  } bda_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/bda_if.sv
// Valid/ready channel interfaces for scan requests and results.
// Depends on bda_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bda_scan_if import bda_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [RAW_BITS-1:0]  raw_levels;
  logic [TIME_BITS-1:0] now_ms;

  modport source (output valid, output raw_levels, output now_ms, input ready);
  modport sink   (input valid, input raw_levels, input now_ms, output ready);
endinterface

interface bda_result_if import bda_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RAW_BITS-1:0] held_mask;
  logic [RAW_BITS-1:0] press_event;
  logic                active;
  logic                shutdown;

  modport source (output valid, output held_mask, output press_event,
                  output active, output shutdown, input ready);
  modport sink   (input valid, input held_mask, input press_event,
                  input active, input shutdown, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bda_lane.sv
// One button lane: history shift, popcount debounce, latch, handler flag
// and press time. Depends on bda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bda_lane import bda_pkg::*; #(
  parameter int unsigned HISTORY_BITS = HISTORY_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic                  pressed,
  input  wire logic                  handler_en,
  input  wire logic [TIME_BITS-1:0]  now_ms,
  input  wire logic [LIMIT_BITS-1:0] sleep_limit,
  input  wire logic [LONG_BITS-1:0]  long_press_ms,
  output lane_flags_t                flags
);

  localparam int unsigned CNT_BITS = $clog2(HISTORY_BITS + 1);

  logic [HISTORY_BITS-1:0] history, history_next;
  logic                    latched, latched_next;
  logic                    done, done_next;
  logic [TIME_BITS-1:0]    press_time, press_time_next;
  logic [CNT_BITS-1:0]     ones;
  logic                    press_ok, release_ok, latch_set, fire;
  logic [TIME_BITS-1:0]    elapsed;

  always_comb begin
    history_next = {history[HISTORY_BITS-2:0], pressed};
    ones = '0;
    for (int b = 0; b < HISTORY_BITS; b++) begin
      ones = ones + CNT_BITS'(history_next[b]);
    end
  end

  always_comb begin
    press_ok   = pressed && (ones >= CNT_BITS'(PRESS_THRESHOLD));
    release_ok = !pressed && (ones <= CNT_BITS'(RELEASE_THRESHOLD));
    latch_set  = press_ok && !latched;
    fire       = press_ok && !done && handler_en;

    latched_next    = press_ok ? 1'b1 : (release_ok ? 1'b0 : latched);
    done_next       = release_ok ? 1'b0 : (done | fire);
    press_time_next = latch_set ? now_ms : press_time;

    // a fresh latch records now, so its elapsed time is zero
    elapsed = latch_set ? '0 : (now_ms - press_time);

    flags.held        = latched_next;
    flags.press_event = fire;
    flags.recent      = elapsed < TIME_BITS'(sleep_limit);
    flags.over_long   = latched_next && (elapsed > TIME_BITS'(long_press_ms));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history    <= '0;
      latched    <= 1'b0;
      done       <= 1'b0;
      press_time <= '0;
    end else if (accept) begin
      history    <= history_next;
      latched    <= latched_next;
      done       <= done_next;
      press_time <= press_time_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bda_merge.sv
// Merging stage: combines lane flags into one result and holds it in an
// output register with a skid entry. Depends on bda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bda_merge import bda_pkg::*; #(
  parameter int unsigned NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire lane_flags_t flags [NUM_BUTTONS],
  input  wire logic        always_active,
  input  wire logic        out_ready,
  output logic             in_ready,
  output logic             out_valid,
  output bda_result_t      result
);

  bda_result_t merged;
  bda_result_t skid;
  logic        skid_valid;
  logic        any_recent;

  always_comb begin
    merged     = '0;
    any_recent = 1'b0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      any_recent = any_recent | flags[i].recent;
    end
    for (int i = 0; i < RAW_BITS; i++) begin
      if (i < NUM_BUTTONS) begin
        merged.held_mask[i]   = flags[i].held;
        merged.press_event[i] = flags[i].press_event;
      end
    end
    merged.active   = always_active | any_recent;
    merged.shutdown = flags[0].over_long;
  end

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      // output register free: drain the skid entry first
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        result <= skid;
      end else if (accept) begin
        result <= merged;
      end
    end else if (accept) begin
      skid <= merged;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/button_debounce_activity.sv
// Top level of the button debounce and activity block: configuration
// registers, one lane per button and the merging stage.
// Depends on bda_pkg, bda_if, bda_lane and bda_merge.
//
// Usage:
//   scan   - one request per scan tick: raw_levels (active low, bit i for
//            button i) and now_ms, the free-running millisecond time.
//   result - one result per request: held_mask, press_event, active and
//            shutdown, in request order.
//   cfg_we/cfg_index/cfg_wdata - register writes, taken on any edge with
//            cfg_we high; write only while no request is in flight.
//   The result is held in the merging stage's output register; a request is
//   accepted every cycle while scan.ready is high. All lanes update in the accepting
//   cycle, each with one popcount, one 32-bit elapsed-time subtract and two compares.
//   When the receiver stalls, one further request is held in a skid entry
//   and scan.ready drops until it drains.
//   Reset clears histories, latches, handler flags and press times, sets
//   sleep_timeout and handler_mask to zero and long_press_ms to 1000.
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_activity import bda_pkg::*; #(
  parameter int unsigned NUM_BUTTONS  = NUM_BUTTONS_DEF,
  parameter int unsigned HISTORY_BITS = HISTORY_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata,
  bda_scan_if.sink                       scan,
  bda_result_if.source                   result
);

  // Sleep limit is kept in milliseconds; zero means always active
  logic [LIMIT_BITS-1:0] sleep_limit;
  logic [MASK_BITS-1:0]  handler_mask;
  logic [LONG_BITS-1:0]  long_press_ms;

  logic        accept;
  logic        in_ready;
  logic        out_valid;
  bda_result_t res;
  lane_flags_t flags [NUM_BUTTONS];

  // Register writes; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      sleep_limit   <= '0;
      handler_mask  <= '0;
      long_press_ms <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SLEEP_TIMEOUT: begin
          sleep_limit <= LIMIT_BITS'(cfg_wdata[SLEEP_BITS-1:0]) *
                         LIMIT_BITS'(MS_PER_UNIT);
        end
        REG_HANDLER_MASK:  handler_mask  <= cfg_wdata[MASK_BITS-1:0];
        REG_LONG_PRESS_MS: long_press_ms <= cfg_wdata[LONG_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign scan.ready = in_ready;
  assign accept     = scan.valid && in_ready;

  // One lane per button; buttons past the pin field read as pressed and
  // have no handler
  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
    logic pressed;
    logic handler_en;

    if (g < RAW_BITS) begin : g_pin
      assign pressed    = !scan.raw_levels[g];
      assign handler_en = handler_mask[g];
    end else begin : g_nopin
      assign pressed    = 1'b1;
      assign handler_en = 1'b0;
    end

    bda_lane #(
      .HISTORY_BITS(HISTORY_BITS)
    ) u_lane (
      .clk          (clk),
      .rst          (rst),
      .accept       (accept),
      .pressed      (pressed),
      .handler_en   (handler_en),
      .now_ms       (scan.now_ms),
      .sleep_limit  (sleep_limit),
      .long_press_ms(long_press_ms),
      .flags        (flags[g])
    );
  end

  bda_merge #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_merge (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .flags        (flags),
    .always_active(sleep_limit == '0),
    .out_ready    (result.ready),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .result       (res)
  );

  assign result.valid       = out_valid;
  assign result.held_mask   = res.held_mask;
  assign result.press_event = res.press_event;
  assign result.active      = res.active;
  assign result.shutdown    = res.shutdown;

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for button_debounce_activity: drives scan requests and
// register writes, predicts every result and compares it field by field.
// Depends on bda_pkg, bda_if and the block itself.
`timescale 1ns / 1ps

module tb;
  import bda_pkg::*;

  localparam int unsigned KEYS = NUM_BUTTONS_DEF;
  localparam int unsigned HIST = HISTORY_BITS_DEF;
  localparam int unsigned PHASES = 14;
  localparam int unsigned PHASE_ITEMS = 48;
  localparam int unsigned HOLD_OFF_CYCLES = 60;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  bda_scan_if scan_ch ();
  bda_result_if res_ch ();

  button_debounce_activity dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .scan(scan_ch),
    .result(res_ch)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Debounce predictor: its own copy of the per-button state and the registers.
  // ---------------------------------------------------------------------------
  logic [HIST-1:0]      key_hist    [KEYS];
  logic                 key_latched [KEYS];
  logic                 key_fired   [KEYS];
  logic [TIME_BITS-1:0] key_down_ms [KEYS];

  logic [SLEEP_BITS-1:0] sleep_units = '0;
  logic [MASK_BITS-1:0]  handler_en  = '0;
  logic [LONG_BITS-1:0]  long_ms     = LONG_PRESS_RESET;

  initial begin
    for (int i = 0; i < KEYS; i++) begin
      key_hist[i] = '0;
      key_latched[i] = 1'b0;
      key_fired[i] = 1'b0;
      key_down_ms[i] = '0;
    end
  end

  // Mirror a register write; an index with no register behind it changes nothing.
  function automatic void apply_reg(cfg_reg_t sel, logic [CFG_DATA_BITS-1:0] data);
    case (sel)
      REG_SLEEP_TIMEOUT: sleep_units = data[SLEEP_BITS-1:0];
      REG_HANDLER_MASK:  handler_en = data[MASK_BITS-1:0];
      REG_LONG_PRESS_MS: long_ms = data[LONG_BITS-1:0];
      default: ;
    endcase
  endfunction

  // Advance the debounce state by one scan tick and return what the block reports.
  function automatic bda_result_t debounce_tick(logic [RAW_BITS-1:0] raw,
                                                logic [TIME_BITS-1:0] now);
    bda_result_t r;
    logic pressed;
    int ones;
    logic [TIME_BITS-1:0] window;
    r = '0;
    for (int i = 0; i < KEYS; i++) begin
      pressed = !raw[i];
      key_hist[i] = {key_hist[i][HIST-2:0], pressed};
      ones = $countones(key_hist[i]);
      if (pressed && ones >= PRESS_THRESHOLD) begin
        if (!key_latched[i]) begin
          key_down_ms[i] = now;
          key_latched[i] = 1'b1;
        end
        if (!key_fired[i] && handler_en[i]) begin
          key_fired[i] = 1'b1;
          r.press_event[i] = 1'b1;
        end
      end else if (!pressed && ones <= RELEASE_THRESHOLD) begin
        key_latched[i] = 1'b0;
        key_fired[i] = 1'b0;
      end
      r.held_mask[i] = key_latched[i];
    end
    // Elapsed times are unsigned 32-bit differences, so they survive the wrap
    window = TIME_BITS'(sleep_units) * MS_PER_UNIT;
    if (sleep_units == '0) begin
      r.active = 1'b1;
    end else begin
      for (int i = 0; i < KEYS; i++) begin
        if (TIME_BITS'(now - key_down_ms[i]) < window) r.active = 1'b1;
      end
    end
    r.shutdown = key_latched[0] && (TIME_BITS'(now - key_down_ms[0]) > TIME_BITS'(long_ms));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Expected results, oldest first, and the mismatch log
  // ---------------------------------------------------------------------------
  bda_result_t scan_reports_due[$];

  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_with_event = 0;
  int n_shutdown = 0;
  int n_inactive = 0;

  task automatic report_mismatch(string msg);
    if (errors < 40) $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check each accepted result, then drive ready for the next edge.
  // A hold-off asked for by the stimulus is counted out here, cycle by cycle.
  // ---------------------------------------------------------------------------
  bit steady = 1'b0;    // no idling on either side while set
  bit hold_req = 1'b0;
  int hold_left = 0;

  always @(posedge clk) begin : result_side
    bda_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (scan_reports_due.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = scan_reports_due.pop_front();
        n_checked++;
        if (want.press_event != '0) n_with_event++;
        if (want.shutdown) n_shutdown++;
        if (!want.active) n_inactive++;
        if (res_ch.held_mask !== want.held_mask)
          report_mismatch($sformatf("held_mask got %b want %b",
                                    res_ch.held_mask, want.held_mask));
        if (res_ch.press_event !== want.press_event)
          report_mismatch($sformatf("press_event got %b want %b",
                                    res_ch.press_event, want.press_event));
        if (res_ch.active !== want.active)
          report_mismatch($sformatf("active got %b want %b", res_ch.active, want.active));
        if (res_ch.shutdown !== want.shutdown)
          report_mismatch($sformatf("shutdown got %b want %b",
                                    res_ch.shutdown, want.shutdown));
      end
    end
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else if (steady) begin
      res_ch.ready <= 1'b1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= 13);
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one scan request, idling now and then, and hold it until taken.
  // On acceptance advance the predictor; a typed-in result replaces its answer.
  task automatic send_tick(logic [RAW_BITS-1:0] raw, logic [TIME_BITS-1:0] now,
                           bit known, bda_result_t known_res);
    bda_result_t pred;
    while (!steady && $urandom_range(99) < 13) begin
      scan_ch.valid <= 1'b0;
      @(posedge clk);
    end
    scan_ch.valid <= 1'b1;
    scan_ch.raw_levels <= raw;
    scan_ch.now_ms <= now;
    do @(posedge clk); while (!scan_ch.ready);
    pred = debounce_tick(raw, now);
    scan_reports_due.push_back(known ? known_res : pred);
    n_sent++;
  endtask

  // Drop valid and wait until every outstanding request has been answered,
  // then allow the pipeline to settle before touching registers.
  task automatic drain_results();
    scan_ch.valid <= 1'b0;
    while (scan_reports_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Raise the write strobe until the write is taken; the caller drops it after the last write.
  task automatic write_reg(cfg_reg_t sel, logic [CFG_DATA_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= data;
    @(posedge clk);
    apply_reg(sel, data);
  endtask

  // Directed script: register writes and scan ticks in order
  typedef struct {
    bit                   is_write;
    cfg_reg_t             sel;
    logic [CFG_DATA_BITS-1:0] data;
    logic [RAW_BITS-1:0]  raw;
    logic [TIME_BITS-1:0] now;
    bit                   known;
    bda_result_t          want;
  } script_row_t;

  script_row_t script[$];

  function automatic void add_write(cfg_reg_t sel, logic [CFG_DATA_BITS-1:0] data);
    script.push_back('{1'b1, sel, data, '0, '0, 1'b0, '0});
  endfunction

  function automatic void add_tick(logic [RAW_BITS-1:0] raw, logic [TIME_BITS-1:0] now);
    script.push_back('{1'b0, REG_UNUSED, '0, raw, now, 1'b0, '0});
  endfunction

  function automatic void add_known(logic [RAW_BITS-1:0] raw, logic [TIME_BITS-1:0] now,
                                    logic [RAW_BITS-1:0] held, logic [RAW_BITS-1:0] ev,
                                    logic act, logic shut);
    script.push_back('{1'b0, REG_UNUSED, '0, raw, now, 1'b1, '{held, ev, act, shut}});
  endfunction

  function automatic logic [SLEEP_BITS-1:0] pick_sleep();
    case ($urandom_range(4))
      0: return '0;
      1: return 8'd1;
      2: return 8'd2;
      3: return 8'd255;
      default: return SLEEP_BITS'($urandom_range(255, 1));
    endcase
  endfunction

  function automatic logic [LONG_BITS-1:0] pick_long();
    case ($urandom_range(4))
      0: return '0;
      1: return LONG_BITS'($urandom_range(200));
      2: return LONG_BITS'($urandom_range(3000));
      3: return 16'hFFFF;
      default: return LONG_BITS'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    bit prev_tick;
    bit noisy;
    logic [RAW_BITS-1:0] lvl;
    logic [RAW_BITS-1:0] raw;
    logic [TIME_BITS-1:0] clock_ms;
    int r;

    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_SLEEP_TIMEOUT;
    cfg_wdata <= '0;
    scan_ch.valid <= 1'b0;
    scan_ch.raw_levels <= '1;
    scan_ch.now_ms <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // --- Directed part ---
    add_write(REG_HANDLER_MASK, 16'd7);
    // Straight after reset the timeout is zero, so the block counts as active
    add_known(3'b111, 32'd0, 3'b000, 3'b000, 1'b1, 1'b0);
    // Never pressed: activity runs from time zero, one unit is 10000 ms
    add_write(REG_SLEEP_TIMEOUT, 16'd1);
    add_known(3'b111, 32'd9999, 3'b000, 3'b000, 1'b1, 1'b0);
    add_known(3'b111, 32'd10000, 3'b000, 3'b000, 1'b0, 1'b0);
    // Index with no register behind it: must leave everything alone
    add_write(REG_UNUSED, 16'hFFFF);
    add_write(REG_SLEEP_TIMEOUT, 16'd0);
    // All three pressed: the fourth set bit latches them and fires all handlers
    add_tick(3'b000, 32'd10);
    add_tick(3'b000, 32'd20);
    add_tick(3'b000, 32'd30);
    add_known(3'b000, 32'd40, 3'b111, 3'b111, 1'b1, 1'b0);
    // Long press of button 0: exactly 1000 ms is not yet over, 1001 is
    add_known(3'b000, 32'd1040, 3'b111, 3'b000, 1'b1, 1'b0);
    add_known(3'b000, 32'd1041, 3'b111, 3'b000, 1'b1, 1'b1);
    // Release: the latch clears once the history falls to four set bits
    add_tick(3'b111, 32'd2000);
    add_tick(3'b111, 32'd2001);
    add_tick(3'b111, 32'd2002);
    add_tick(3'b111, 32'd2003);
    // Press just before the time wraps, handler off, zero long-press time
    add_write(REG_SLEEP_TIMEOUT, 16'd255);
    add_write(REG_HANDLER_MASK, 16'd0);
    add_write(REG_LONG_PRESS_MS, 16'd0);
    add_tick(3'b110, 32'hFFFF_FFF0);
    add_tick(3'b110, 32'hFFFF_FFF8);
    // Handler enabled while still latched: the event fires late, once
    add_write(REG_HANDLER_MASK, 16'd1);
    add_tick(3'b110, 32'd5);
    add_write(REG_LONG_PRESS_MS, 16'hFFFF);
    add_tick(3'b110, 32'h0001_0000);
    // Bouncing contacts on all three buttons
    add_tick(3'b101, 32'h0001_0010);
    add_tick(3'b010, 32'h0001_0020);
    add_tick(3'b101, 32'h0001_0030);
    add_tick(3'b010, 32'h0001_0040);
    add_tick(3'b111, 32'hFFFF_FFFF);

    prev_tick = 1'b0;
    foreach (script[i]) begin
      if (script[i].is_write) begin
        if (prev_tick) drain_results();
        write_reg(script[i].sel, script[i].data);
        prev_tick = 1'b0;
      end else begin
        if (!prev_tick) cfg_we <= 1'b0;
        send_tick(script[i].raw, script[i].now, script[i].known, script[i].want);
        prev_tick = 1'b1;
      end
    end

    // --- Random part: per-button levels that settle and bounce, paced time ---
    lvl = '1;
    clock_ms = $urandom;
    for (int k = 0; k < PHASES; k++) begin
      drain_results();
      steady = (k == 3);
      noisy = (k == 10 || k == 11);
      case (k)
        0: begin
          write_reg(REG_SLEEP_TIMEOUT, {8'($urandom), 8'd255});
          write_reg(REG_HANDLER_MASK, {13'($urandom), 3'd7});
          write_reg(REG_LONG_PRESS_MS, 16'd0);
        end
        1: begin
          write_reg(REG_SLEEP_TIMEOUT, {8'($urandom), 8'd0});
          write_reg(REG_HANDLER_MASK, {13'($urandom), 3'd0});
          write_reg(REG_LONG_PRESS_MS, 16'hFFFF);
        end
        2: begin
          write_reg(REG_SLEEP_TIMEOUT, 16'd1);
          write_reg(REG_HANDLER_MASK, 16'd7);
          write_reg(REG_LONG_PRESS_MS, 16'd500);
        end
        default: begin
          if ($urandom_range(2) != 0) write_reg(REG_SLEEP_TIMEOUT, {8'($urandom), pick_sleep()});
          if ($urandom_range(2) != 0)
            write_reg(REG_HANDLER_MASK, {13'($urandom), 3'($urandom_range(7))});
          if ($urandom_range(2) != 0) write_reg(REG_LONG_PRESS_MS, pick_long());
          if ($urandom_range(3) == 0) write_reg(REG_UNUSED, 16'($urandom));
        end
      endcase
      cfg_we <= 1'b0;

      // Now and then start close to the wrap of the millisecond counter
      if ($urandom_range(3) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(3000);
      // Stall the receiver for a long stretch while requests keep coming
      if (k == 5) hold_req = 1'b1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Pause the sender until every result is back
        if (k == 8 && n == PHASE_ITEMS / 2) drain_results();
        if (noisy) begin
          raw = RAW_BITS'($urandom);
          clock_ms = ($urandom_range(1) == 0) ? TIME_BITS'($urandom) : clock_ms + 10;
        end else begin
          raw = lvl;
          for (int b = 0; b < KEYS; b++) begin
            r = $urandom_range(99);
            if (r < 6) begin
              lvl[b] = !lvl[b];
              raw[b] = lvl[b];
            end else if (r < 10) begin
              raw[b] = !lvl[b];
            end
          end
          r = $urandom_range(99);
          if (r < 70) clock_ms = clock_ms + 10;
          else if (r < 85) clock_ms = clock_ms + $urandom_range(2000);
          else if (r < 95) clock_ms = clock_ms + $urandom_range(40000);
          else clock_ms = $urandom;
        end
        send_tick(raw, clock_ms, 1'b0, '0);
      end
    end

    // --- Wind down: wait for the last results, with a bound ---
    scan_ch.valid <= 1'b0;
    for (int c = 0; c < 1000 && scan_reports_due.size() != 0; c++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (scan_reports_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", scan_reports_due.size()));

    $display("Summary: %0d scan requests sent, %0d results checked over %0d register phases.",
             n_sent, n_checked, PHASES);
    $display("Summary: %0d with press events, %0d asking for shutdown, %0d inactive; %0d mismatches.",
             n_with_event, n_shutdown, n_inactive, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
